[design/intel_hex_record_encoder_defines.svh]
// assertion macros for the intel hex record encoder
// depends on nothing; included by the encoder, the file that carries assertions
`ifndef INTEL_HEX_RECORD_ENCODER_DEFINES_SVH
`define INTEL_HEX_RECORD_ENCODER_DEFINES_SVH
`ifndef SYNTHESIS
`define IHRE_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define IHRE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define IHRE_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define IHRE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

[design/ihre_pkg.sv]
// types, constants and the control store of the intel hex record encoder
// depends on nothing
package ihre_pkg;

   localparam logic [7:0] CHAR_COLON   = 8'h3A;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam int         MAX_PIECES   = 38;
   localparam int         PCNT_W       = 6;
   localparam int         PC_W         = 5;
   localparam logic [PC_W-1:0] PC_UPPER = 5'd0;
   localparam logic [PC_W-1:0] PC_DATA  = 5'd9;
   localparam logic [PC_W-1:0] PC_EOF   = 5'd17;
   localparam logic [1:0] CSR_BASE_IDX  = 2'd0;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   typedef enum logic [3:0] {
      SRC_COLON,
      SRC_NEWLINE,
      SRC_CONST,
      SRC_UHI,
      SRC_ULO,
      SRC_UCHK,
      SRC_CNT,
      SRC_AHI,
      SRC_ALO,
      SRC_BUF,
      SRC_DCHK
   } src_type;

   typedef enum logic [2:0] {
      CTL_NEXT,
      CTL_LOOP,
      CTL_END_UPPER,
      CTL_END_DATA,
      CTL_END_EOF
   } ctl_type;

   typedef struct packed {
      src_type    src;
      logic [7:0] konst;
      ctl_type    ctl;
   } cword_type;

   function automatic cword_type ucode(input logic [PC_W-1:0] pc);
      cword_type w;
      w = '{src: SRC_NEWLINE, konst: 8'h00, ctl: CTL_END_EOF};
      unique case (pc)
         // extended linear address record
         5'd0:  w = '{src: SRC_COLON,   konst: 8'h00, ctl: CTL_NEXT};
         5'd1:  w = '{src: SRC_CONST,   konst: 8'h02, ctl: CTL_NEXT};
         5'd2:  w = '{src: SRC_CONST,   konst: 8'h00, ctl: CTL_NEXT};
         5'd3:  w = '{src: SRC_CONST,   konst: 8'h00, ctl: CTL_NEXT};
         5'd4:  w = '{src: SRC_CONST,   konst: 8'h04, ctl: CTL_NEXT};
         5'd5:  w = '{src: SRC_UHI,     konst: 8'h00, ctl: CTL_NEXT};
         5'd6:  w = '{src: SRC_ULO,     konst: 8'h00, ctl: CTL_NEXT};
         5'd7:  w = '{src: SRC_UCHK,    konst: 8'h00, ctl: CTL_NEXT};
         5'd8:  w = '{src: SRC_NEWLINE, konst: 8'h00, ctl: CTL_END_UPPER};
         // data record
         5'd9:  w = '{src: SRC_COLON,   konst: 8'h00, ctl: CTL_NEXT};
         5'd10: w = '{src: SRC_CNT,     konst: 8'h00, ctl: CTL_NEXT};
         5'd11: w = '{src: SRC_AHI,     konst: 8'h00, ctl: CTL_NEXT};
         5'd12: w = '{src: SRC_ALO,     konst: 8'h00, ctl: CTL_NEXT};
         5'd13: w = '{src: SRC_CONST,   konst: 8'h00, ctl: CTL_NEXT};
         5'd14: w = '{src: SRC_BUF,     konst: 8'h00, ctl: CTL_LOOP};
         5'd15: w = '{src: SRC_DCHK,    konst: 8'h00, ctl: CTL_NEXT};
         5'd16: w = '{src: SRC_NEWLINE, konst: 8'h00, ctl: CTL_END_DATA};
         // end of file record
         5'd17: w = '{src: SRC_COLON,   konst: 8'h00, ctl: CTL_NEXT};
         5'd18: w = '{src: SRC_CONST,   konst: 8'h00, ctl: CTL_NEXT};
         5'd19: w = '{src: SRC_CONST,   konst: 8'h00, ctl: CTL_NEXT};
         5'd20: w = '{src: SRC_CONST,   konst: 8'h00, ctl: CTL_NEXT};
         5'd21: w = '{src: SRC_CONST,   konst: 8'h01, ctl: CTL_NEXT};
         5'd22: w = '{src: SRC_CONST,   konst: 8'hFF, ctl: CTL_NEXT};
         5'd23: w = '{src: SRC_NEWLINE, konst: 8'h00, ctl: CTL_END_EOF};
         default: w = '{src: SRC_NEWLINE, konst: 8'h00, ctl: CTL_END_EOF};
      endcase
      return w;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      return (nib < 4'd10) ? (8'h30 + {4'h0, nib}) : (8'h37 + {4'h0, nib});
   endfunction

endpackage

[design/ihre_req_if.sv]
// input channel of the intel hex record encoder: one raw image byte per word
// depends on nothing
interface ihre_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

[design/ihre_rsp_if.sv]
// result channel of the intel hex record encoder: one text piece per word
// depends on nothing
interface ihre_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] first_char;
   logic [7:0] second_char;
   logic [1:0] char_count;
   logic       run_last;

   modport source (output valid, output first_char, output second_char,
                   output char_count, output run_last, input ready);
   modport sink   (input valid, input first_char, input second_char,
                   input char_count, input run_last, output ready);
endinterface

[design/intel_hex_record_encoder.sv]
// intel hex encoder: a middle byte is taken with no output words
// a byte that opens or closes a record runs a microcode program at one word per cycle
// while the result channel is not stalled: 9 words for a type 04 record, fill count + 7
// for a data record, 7 for end of file; input is held off while the program runs
// synchronous active-high reset clears control state; record buffer needs no clearing
`include "intel_hex_record_encoder_defines.svh"
module intel_hex_record_encoder #(
   parameter int RECORD_BYTES = 16
) (
   input  logic        clock,
   input  logic        reset,
   ihre_req_if.sink    req_ch,
   ihre_rsp_if.source  rsp_ch,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int FILL_W = $clog2(RECORD_BYTES + 1);
   localparam int IDX_W  = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;

   // configuration
   logic [31:0] base_ff;
   logic        csr_wr;

   // architectural record state
   logic [7:0]        buf_ff [RECORD_BYTES];
   logic [7:0]        buf_rd_ff;
   logic [FILL_W-1:0] fill_ff,  fill_in;
   logic [31:0]       rsa_ff,   rsa_in;
   logic [15:0]       cur_ff,   cur_in;
   logic              hs_ff,    hs_in;
   logic [7:0]        sum_ff,   sum_in;

   // per-byte snapshot for the program
   logic [15:0]       up_ff,    up_in;
   logic [7:0]        uchk_ff,  uchk_in;
   logic [FILL_W-1:0] cnt_ff,   cnt_in;
   logic [15:0]       alo_ff,   alo_in;
   logic [7:0]        dchk_ff,  dchk_in;
   logic              dodat_ff, dodat_in;
   logic              doend_ff, doend_in;

   // sequencer
   ihre_pkg::state_type        state_ff, state_in;
   logic [ihre_pkg::PC_W-1:0]  pc_ff,    pc_in;
   logic [FILL_W-1:0]          idx_ff,   idx_in;
   logic [ihre_pkg::PCNT_W-1:0] pcnt_ff, pcnt_in;

   // output register
   logic       ov_ff,  ov_in;
   logic [7:0] oc1_ff, oc1_in;
   logic [7:0] oc2_ff, oc2_in;
   logic [1:0] ocn_ff, ocn_in;
   logic       olast_ff, olast_in;

   // accept side
   logic              req_acc;
   logic              do_upper;
   logic              flush;
   logic [31:0]       rsa_eff;
   logic [FILL_W-1:0] fill_new;
   logic [7:0]        sum_new;
   logic [7:0]        cnt8;

   // issue side
   ihre_pkg::cword_type cw;
   logic                out_free;
   logic                issue;
   logic                fin;
   logic [7:0]          hbyte;

   // csr port: one register, always ready
   assign csr_pready = 1'b1;
   assign csr_prdata = base_ff;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite &&
                       ((csr_paddr >> 2) == ihre_pkg::CSR_BASE_IDX);

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
      end else if (csr_wr) begin
         base_ff <= csr_pwdata;
      end
   end

   assign req_ch.ready = (state_ff == ihre_pkg::ST_IDLE);
   assign req_acc      = req_ch.valid && req_ch.ready;

   // byte intake: decide which records this byte opens or closes
   always_comb begin
      // the first byte of an image picks up the base address
      rsa_eff  = (fill_ff == '0 && !hs_ff) ? base_ff : rsa_ff;
      do_upper = (fill_ff == '0) && (!hs_ff || (rsa_ff[31:16] != cur_ff));
      fill_new = fill_ff + 1'b1;
      sum_new  = sum_ff + req_ch.data_byte;
      flush    = (fill_new == FILL_W'(RECORD_BYTES)) || req_ch.last_byte;
      cnt8     = 8'(fill_new);

      up_in    = rsa_eff[31:16];
      uchk_in  = 8'h00 - (8'h06 + rsa_eff[31:24] + rsa_eff[23:16]);
      cnt_in   = fill_new;
      alo_in   = rsa_eff[15:0];
      dchk_in  = 8'h00 - (cnt8 + rsa_eff[15:8] + rsa_eff[7:0] + sum_new);
      dodat_in = flush;
      doend_in = req_ch.last_byte;

      cur_in   = (fill_ff == '0) ? rsa_eff[31:16] : cur_ff;
      hs_in    = !req_ch.last_byte;
      fill_in  = flush ? '0 : fill_new;
      sum_in   = flush ? 8'h00 : sum_new;
      rsa_in   = flush ? (rsa_eff + 32'(fill_new)) : rsa_eff;
   end

   always_ff @(posedge clock) begin
      // registered buffer read, addressed by the next index so the data lines up with the issue
      buf_rd_ff <= buf_ff[idx_in[IDX_W-1:0]];
      if (req_acc) begin
         buf_ff[fill_ff[IDX_W-1:0]] <= req_ch.data_byte;
         up_ff    <= up_in;
         uchk_ff  <= uchk_in;
         cnt_ff   <= cnt_in;
         alo_ff   <= alo_in;
         dchk_ff  <= dchk_in;
         dodat_ff <= dodat_in;
         doend_ff <= doend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         rsa_ff  <= '0;
         cur_ff  <= '0;
         hs_ff   <= 1'b0;
         sum_ff  <= '0;
      end else if (req_acc) begin
         fill_ff <= fill_in;
         rsa_ff  <= rsa_in;
         cur_ff  <= cur_in;
         hs_ff   <= hs_in;
         sum_ff  <= sum_in;
      end
   end

   // microcode issue: one control word per word sent
   assign cw       = ihre_pkg::ucode(pc_ff);
   assign out_free = !ov_ff || rsp_ch.ready;
   assign issue    = (state_ff == ihre_pkg::ST_RUN) && out_free;

   always_comb begin
      // hex byte mux
      case (cw.src)
         ihre_pkg::SRC_UHI:  hbyte = up_ff[15:8];
         ihre_pkg::SRC_ULO:  hbyte = up_ff[7:0];
         ihre_pkg::SRC_UCHK: hbyte = uchk_ff;
         ihre_pkg::SRC_CNT:  hbyte = 8'(cnt_ff);
         ihre_pkg::SRC_AHI:  hbyte = alo_ff[15:8];
         ihre_pkg::SRC_ALO:  hbyte = alo_ff[7:0];
         ihre_pkg::SRC_BUF:  hbyte = buf_rd_ff;
         ihre_pkg::SRC_DCHK: hbyte = dchk_ff;
         default:            hbyte = cw.konst;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      idx_in   = idx_ff;
      pcnt_in  = pcnt_ff;
      fin      = 1'b0;
      ov_in    = ov_ff && !rsp_ch.ready;
      oc1_in   = oc1_ff;
      oc2_in   = oc2_ff;
      ocn_in   = ocn_ff;
      olast_in = olast_ff;

      unique case (state_ff)
         ihre_pkg::ST_IDLE: begin
            idx_in  = '0;
            pcnt_in = '0;
            if (req_acc && do_upper) begin
               pc_in    = ihre_pkg::PC_UPPER;
               state_in = ihre_pkg::ST_RUN;
            end else if (req_acc && flush) begin
               pc_in    = ihre_pkg::PC_DATA;
               state_in = ihre_pkg::ST_RUN;
            end
         end
         ihre_pkg::ST_RUN: begin
            if (issue) begin
               // next control word and end of program
               case (cw.ctl)
                  ihre_pkg::CTL_LOOP: begin
                     if ((idx_ff + 1'b1) == cnt_ff) begin
                        pc_in  = pc_ff + 1'b1;
                        idx_in = '0;
                     end else begin
                        idx_in = idx_ff + 1'b1;
                     end
                  end
                  ihre_pkg::CTL_END_UPPER: begin
                     pc_in = ihre_pkg::PC_DATA;
                     fin   = !dodat_ff;
                  end
                  ihre_pkg::CTL_END_DATA: begin
                     pc_in = ihre_pkg::PC_EOF;
                     fin   = !doend_ff;
                  end
                  ihre_pkg::CTL_END_EOF: fin = 1'b1;
                  default:               pc_in = pc_ff + 1'b1;
               endcase
               // pieces past the per-byte limit are dropped
               if (pcnt_ff == ihre_pkg::PCNT_W'(ihre_pkg::MAX_PIECES - 1)) begin
                  fin = 1'b1;
               end
               pcnt_in = pcnt_ff + 1'b1;
               if (fin) begin
                  state_in = ihre_pkg::ST_IDLE;
               end

               // load the output word
               ov_in    = 1'b1;
               olast_in = fin;
               case (cw.src)
                  ihre_pkg::SRC_COLON: begin
                     oc1_in = ihre_pkg::CHAR_COLON;
                     oc2_in = 8'h00;
                     ocn_in = 2'd1;
                  end
                  ihre_pkg::SRC_NEWLINE: begin
                     oc1_in = ihre_pkg::CHAR_NEWLINE;
                     oc2_in = 8'h00;
                     ocn_in = 2'd1;
                  end
                  default: begin
                     oc1_in = ihre_pkg::hex_char(hbyte[7:4]);
                     oc2_in = ihre_pkg::hex_char(hbyte[3:0]);
                     ocn_in = 2'd2;
                  end
               endcase
            end
         end
         default: state_in = ihre_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ihre_pkg::ST_IDLE;
         pc_ff    <= '0;
         idx_ff   <= '0;
         pcnt_ff  <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         idx_ff   <= idx_in;
         pcnt_ff  <= pcnt_in;
         ov_ff    <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      oc1_ff   <= oc1_in;
      oc2_ff   <= oc2_in;
      ocn_ff   <= ocn_in;
      olast_ff <= olast_in;
   end

   assign rsp_ch.valid       = ov_ff;
   assign rsp_ch.first_char  = oc1_ff;
   assign rsp_ch.second_char = oc2_ff;
   assign rsp_ch.char_count  = ocn_ff;
   assign rsp_ch.run_last    = olast_ff;

   // checks
   `IHRE_ASSERT_SAME(a_single_char, clock, reset, rsp_ch.valid && rsp_ch.char_count == 2'd1, (rsp_ch.first_char == ihre_pkg::CHAR_COLON || rsp_ch.first_char == ihre_pkg::CHAR_NEWLINE) && rsp_ch.second_char == 8'h00, "single-char word is not colon or newline")
   `IHRE_ASSERT_SAME(a_fill_range, clock, reset, 1'b1, fill_ff < FILL_W'(RECORD_BYTES), "fill count reached record size")
   `IHRE_ASSERT_SAME(a_loop_index, clock, reset, state_ff == ihre_pkg::ST_RUN && cw.ctl == ihre_pkg::CTL_LOOP, idx_ff < cnt_ff, "buffer index beyond record count")
   `IHRE_ASSERT_NEXT(a_last_clears, clock, reset, req_acc && req_ch.last_byte, fill_ff == '0 && !hs_ff, "image state not cleared after last byte")

endmodule

[verif/ihre_text_pkg.sv]
// expected-text scoreboard for the intel hex record encoder testbench
// depends on ihre_pkg for the colon, newline and piece-limit constants
package ihre_text_pkg;

   typedef struct packed {
      logic [7:0] first_char;
      logic [7:0] second_char;
      logic [1:0] char_count;
      logic       run_last;
   } text_piece_type;

   localparam logic [7:0] REC_TYPE_DATA       = 8'h00;
   localparam logic [7:0] REC_TYPE_EOF        = 8'h01;
   localparam logic [7:0] REC_TYPE_EXT_LINEAR = 8'h04;
   localparam logic [7:0] EXT_LINEAR_LEN      = 8'h02;
   localparam logic [7:0] EOF_CHECKSUM        = 8'hFF;
   localparam logic [1:0] PIECE_ONE_CHAR      = 2'd1;
   localparam logic [1:0] PIECE_HEX_PAIR      = 2'd2;

   class hex_text_scoreboard #(int RECORD_BYTES = 16);
      // encoder image state, mirrored
      logic [31:0] base_addr;
      logic [7:0]  held_bytes [RECORD_BYTES];
      int          fill;
      logic [31:0] rec_addr;
      logic [15:0] upper_sent;
      bit          in_image;
      logic [7:0]  data_sum;

      text_piece_type step_pieces[$];
      text_piece_type expected_pieces[$];
      int unsigned mismatches;
      int unsigned piece_seq;

      function new();
         base_addr = '0;
         fill = 0;
         rec_addr = '0;
         upper_sent = '0;
         in_image = 1'b0;
         data_sum = '0;
         mismatches = 0;
         piece_seq = 0;
      endfunction

      function void set_base(logic [31:0] value);
         base_addr = value;
      endfunction

      function int pending();
         return expected_pieces.size();
      endfunction

      function logic [7:0] ascii_nibble(logic [3:0] nib);
         // '0'..'9' then 'A'..'F'
         return (nib < 4'd10) ? 8'h30 + 8'(nib) : 8'h41 + 8'(nib - 4'd10);
      endfunction

      function void push_piece(logic [7:0] c1, logic [7:0] c2, logic [1:0] cnt);
         text_piece_type p;
         // anything past the per-byte limit is dropped
         if (step_pieces.size() < ihre_pkg::MAX_PIECES) begin
            p = '{first_char: c1, second_char: c2, char_count: cnt, run_last: 1'b0};
            step_pieces = {step_pieces, p};
         end
      endfunction

      function void push_char(logic [7:0] c);
         push_piece(c, 8'h00, PIECE_ONE_CHAR);
      endfunction

      function void push_hex(logic [7:0] b);
         push_piece(ascii_nibble(b[7:4]), ascii_nibble(b[3:0]), PIECE_HEX_PAIR);
      endfunction

      function void emit_upper(logic [15:0] upper);
         logic [7:0] sum;
         sum = EXT_LINEAR_LEN + REC_TYPE_EXT_LINEAR + upper[15:8] + upper[7:0];
         push_char(ihre_pkg::CHAR_COLON);
         push_hex(EXT_LINEAR_LEN);
         push_hex(8'h00);
         push_hex(8'h00);
         push_hex(REC_TYPE_EXT_LINEAR);
         push_hex(upper[15:8]);
         push_hex(upper[7:0]);
         push_hex(8'h00 - sum);
         push_char(ihre_pkg::CHAR_NEWLINE);
      endfunction

      function void emit_data();
         logic [7:0] sum;
         logic [7:0] cnt;
         cnt = 8'(fill);
         sum = cnt + rec_addr[15:8] + rec_addr[7:0] + data_sum;
         push_char(ihre_pkg::CHAR_COLON);
         push_hex(cnt);
         push_hex(rec_addr[15:8]);
         push_hex(rec_addr[7:0]);
         push_hex(REC_TYPE_DATA);
         for (int i = 0; i < fill; i++)
            push_hex(held_bytes[i]);
         push_hex(8'h00 - sum);
         push_char(ihre_pkg::CHAR_NEWLINE);
      endfunction

      function void emit_eof();
         push_char(ihre_pkg::CHAR_COLON);
         push_hex(8'h00);
         push_hex(8'h00);
         push_hex(8'h00);
         push_hex(REC_TYPE_EOF);
         push_hex(EOF_CHECKSUM);
         push_char(ihre_pkg::CHAR_NEWLINE);
      endfunction

      // text pieces that one accepted byte releases
      function void encode_byte(logic [7:0] data_byte, logic last_byte);
         step_pieces.delete();
         if (fill == 0) begin
            if (!in_image) begin
               rec_addr = base_addr;
               upper_sent = base_addr[31:16];
               in_image = 1'b1;
               emit_upper(upper_sent);
            end else if (rec_addr[31:16] != upper_sent) begin
               upper_sent = rec_addr[31:16];
               emit_upper(upper_sent);
            end
         end
         if (fill < RECORD_BYTES) begin
            held_bytes[fill] = data_byte;
            fill++;
            data_sum += data_byte;
         end
         if (fill >= RECORD_BYTES || last_byte) begin
            emit_data();
            rec_addr += 32'(fill);
            fill = 0;
            data_sum = '0;
         end
         if (last_byte) begin
            emit_eof();
            in_image = 1'b0;
         end
         if (step_pieces.size() > 0)
            step_pieces[step_pieces.size() - 1].run_last = 1'b1;
         expected_pieces = {expected_pieces, step_pieces};
      endfunction

      task flag_mismatch(string msg);
         $display("ERROR: %s", msg);
         mismatches++;
      endtask

      task check_piece(text_piece_type got);
         text_piece_type want;
         piece_seq++;
         if (expected_pieces.size() == 0) begin
            flag_mismatch($sformatf("piece %0d: %h %h count %0d with nothing expected",
                                    piece_seq, got.first_char, got.second_char,
                                    got.char_count));
            return;
         end
         want = expected_pieces.pop_front();
         if (got.first_char !== want.first_char)
            flag_mismatch($sformatf("piece %0d: first_char %h, want %h",
                                    piece_seq, got.first_char, want.first_char));
         if (got.second_char !== want.second_char)
            flag_mismatch($sformatf("piece %0d: second_char %h, want %h",
                                    piece_seq, got.second_char, want.second_char));
         if (got.char_count !== want.char_count)
            flag_mismatch($sformatf("piece %0d: char_count %0d, want %0d",
                                    piece_seq, got.char_count, want.char_count));
         if (got.run_last !== want.run_last)
            flag_mismatch($sformatf("piece %0d: run_last %b, want %b",
                                    piece_seq, got.run_last, want.run_last));
      endtask

      task flag_leftovers();
         if (expected_pieces.size() > 0)
            flag_mismatch($sformatf("%0d expected pieces never came out",
                                    expected_pieces.size()));
      endtask
   endclass

endpackage

[verif/tb_intel_hex_record_encoder.sv]
// testbench top for the intel hex record encoder: feeds raw image bytes under
// several base addresses and checks every text piece; needs ihre_pkg, the two
// channel interfaces, ihre_text_pkg and the encoder itself
module tb_intel_hex_record_encoder;

   localparam int          RECORD_BYTES  = 16;
   localparam logic [1:0]  BASE_OFFSET   = 2'(4 * ihre_pkg::CSR_BASE_IDX);
   // a full data record plus end of file is about 30 words; leave margin
   localparam int          SETTLE_CYCLES = 50;
   localparam int          DRAIN_LIMIT   = 20000;
   localparam int          LONG_HOLD     = 400;
   localparam int          TOTAL_BYTES   = 100;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [1:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   ihre_req_if req_ch();
   ihre_rsp_if rsp_ch();

   ihre_text_pkg::hex_text_scoreboard #(RECORD_BYTES) sb;

   // idle behavior, steered per phase by the stimulus
   int  feed_gap_pct;
   int  rsp_stall_pct;
   bit  rsp_long_hold_req;
   int  bytes_sent;

   intel_hex_record_encoder #(.RECORD_BYTES(RECORD_BYTES)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly short idle stretches, now and then a long one
   function automatic int idle_length();
      if ($urandom_range(0, 15) < 13)
         return $urandom_range(1, 3);
      return $urandom_range(20, 40);
   endfunction

   // apb write: setup cycle, then access cycle; lands when pready is seen
   task automatic write_base(input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= BASE_OFFSET;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.set_base(value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // offer one byte, optionally after a gap; returns once the word is taken
   task automatic send_byte(input logic [7:0] data_byte, input logic is_last);
      int gap;
      gap = ($urandom_range(0, 99) < feed_gap_pct) ? idle_length() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= data_byte;
      req_ch.last_byte <= is_last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.encode_byte(data_byte, is_last);
      bytes_sent++;
   endtask

   // random-content run of bytes, closing the image if asked
   task automatic send_run(input int len, input bit close);
      for (int i = 0; i < len; i++)
         send_byte(8'($urandom), close && (i == len - 1));
   endtask

   // stop feeding, let all text drain, then move the base address
   task automatic begin_phase(input logic [31:0] base);
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      // a byte in mid-record leaves nothing expected but may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_base(base);
   endtask

   // image length: mostly short, some exactly one or two records, a few longer
   function automatic int image_length();
      case ($urandom_range(0, 9)) inside
         [0:5]:   return $urandom_range(1, 20);
         6:       return RECORD_BYTES;
         7:       return 2 * RECORD_BYTES;
         8:       return 1;
         default: return $urandom_range(2 * RECORD_BYTES + 1, 3 * RECORD_BYTES);
      endcase
   endfunction

   function automatic logic [31:0] pick_base();
      case ($urandom_range(0, 4))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         // just below a 64k boundary, so records cross into a new upper half
         2:       return {16'($urandom), 12'hFFF, 4'($urandom)};
         3:       return $urandom;
         default: return {16'hFFFF, 16'($urandom)};
      endcase
   endfunction

   // result side: ready is decided at each falling edge, one assignment per edge
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_long_hold_req) begin
            // long hold-off so the encoder backs up into its input
            stall_left = LONG_HOLD;
            rsp_long_hold_req = 1'b0;
         end
         if (reset) begin
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else if ($urandom_range(0, 99) < rsp_stall_pct) begin
            rsp_ch.ready <= 1'b0;
            stall_left = idle_length() - 1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // every word taken on the result side goes to the scoreboard
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
         sb.check_piece('{first_char:  rsp_ch.first_char,
                          second_char: rsp_ch.second_char,
                          char_count:  rsp_ch.char_count,
                          run_last:    rsp_ch.run_last});
   end

   initial begin
      int carry;
      int cut;
      int len;
      int n_images;
      int phase;
      sb = new();
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data_byte = 8'h00;
      req_ch.last_byte = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      feed_gap_pct = 0;
      rsp_stall_pct = 0;
      rsp_long_hold_req = 1'b0;
      bytes_sent = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: one-byte images at the lowest base with extreme data
      begin_phase(32'h0000_0000);
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);

      // full record starting just below the top of memory; the next record wraps past
      // zero and needs a new upper half, then closes as a one-byte record
      feed_gap_pct = 30;
      rsp_stall_pct = 30;
      begin_phase(32'hFFFF_FFF8);
      send_run(RECORD_BYTES + 1, 1'b1);

      // base moved in mid-image: only the next image may pick it up
      begin_phase(32'h0001_2345);
      send_run(3, 1'b0);
      begin_phase(32'hFFFF_FFFF);
      send_run(2, 1'b1);
      // single byte at the highest address
      send_byte(8'($urandom), 1'b1);

      // random phases
      carry = 0;
      phase = 0;
      while (bytes_sent < TOTAL_BYTES) begin
         if (phase == 0) begin
            begin_phase(32'h0000_FFF5);
            // sender keeps pushing while the receiver sits on its hands
            feed_gap_pct = 0;
            rsp_stall_pct = 0;
            rsp_long_hold_req = 1'b1;
         end else begin
            begin_phase(pick_base());
            case ($urandom_range(0, 3))
               0:       feed_gap_pct = 0;
               1:       feed_gap_pct = 20;
               default: feed_gap_pct = 50;
            endcase
            case ($urandom_range(0, 3))
               0:       rsp_stall_pct = 0;
               1:       rsp_stall_pct = 20;
               default: rsp_stall_pct = 50;
            endcase
         end
         // finish an image left open by the previous phase under the old base
         if (carry > 0) begin
            send_run(carry, 1'b1);
            carry = 0;
         end
         n_images = $urandom_range(1, 3);
         for (int k = 0; k < n_images; k++) begin
            len = image_length();
            if (k == n_images - 1 && len > 1 && $urandom_range(0, 3) == 0) begin
               cut = $urandom_range(1, len - 1);
               send_run(cut, 1'b0);
               carry = len - cut;
            end else begin
               send_run(len, 1'b1);
            end
         end
         phase++;
      end
      if (carry > 0)
         send_run(carry, 1'b1);

      // drain, bounded, then allow for anything still in flight
      @(negedge clock);
      req_ch.valid <= 1'b0;
      for (int i = 0; i < DRAIN_LIMIT && sb.pending() > 0; i++)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      sb.flag_leftovers();
      if (sb.mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // watchdog well beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
